[rtl/dbd_pkg.sv]
// Shared types, constants and calendar helpers for the date difference unit.
package dbd_pkg;

   // Field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 23;
   localparam int MOD_W   = 9;   // holds a year modulo 400
   localparam int TERM_W  = 10;  // signed month/day difference, -366 .. 366
   localparam int ACC_W   = 24;  // whole-year day sum, up to 16383 * 366

   // Calendar constants
   localparam int YEAR_CYCLE  = 400;
   localparam int DAYS_COMMON = 365;
   localparam int DAYS_LEAP   = 366;
   localparam int DEC_OFFSET  = 334;
   localparam int COUNT_MAX   = 4194303;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Compare-subtract ladder that brings a year below 400, largest step first
   localparam int REDUCE_STEPS = 6;
   localparam logic [YEAR_W-1:0] REDUCE_STEP [0:REDUCE_STEPS-1] = '{
      14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400
   };

   // Days before each month, common year, January to November
   localparam logic [8:0] MONTH_START [0:10] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304
   };

   typedef enum logic [1:0] {
      F_IDLE,
      F_REDUCE,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_LOOP,
      B_DONE
   } back_state_type;

   // One classified job handed from front to back
   typedef struct packed {
      logic [YEAR_W-1:0]        start_year;
      logic [MOD_W-1:0]         start_mod;
      logic [YEAR_W-1:0]        end_year;
      logic signed [TERM_W-1:0] md_term;
   } job_type;

   // Queue handshake seen by the two sides
   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_sts_type;

   // Gregorian leap test from the low two year bits and the year modulo 400
   function automatic logic is_leap(input logic [1:0] low_bits,
                                    input logic [MOD_W-1:0] mod400);
      logic century;
      century = (mod400 == 9'd100) || (mod400 == 9'd200) || (mod400 == 9'd300);
      return (low_bits == 2'd0) && ((mod400 == 9'd0) || !century);
   endfunction

   // Days before the given month; anything but 1 to 11 takes December's offset
   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] month,
                                                    input logic leap);
      logic [8:0] off;
      logic [3:0] idx;
      idx = month - 4'd1;
      if (month >= 4'd1 && month <= 4'd11) begin
         off = MONTH_START[idx];
         if (leap && month >= 4'd3) off = off + 9'd1;
      end else begin
         off = 9'(DEC_OFFSET) + {8'd0, leap};
      end
      return off;
   endfunction

endpackage

[rtl/dbd_front.sv]
// Front end: takes a request beat, reduces both years modulo 400, builds the month/day term.
module dbd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [dbd_pkg::YEAR_W-1:0]      req_start_year,
   input  logic [dbd_pkg::MONTH_W-1:0]     req_start_month,
   input  logic [dbd_pkg::DAY_W-1:0]       req_start_day,
   input  logic [dbd_pkg::YEAR_W-1:0]      req_end_year,
   input  logic [dbd_pkg::MONTH_W-1:0]     req_end_month,
   input  logic [dbd_pkg::DAY_W-1:0]       req_end_day,
   output logic                            job_push,
   input  logic                            job_full,
   output dbd_pkg::job_type                job
);

   localparam logic [2:0] LAST_STEP = 3'(dbd_pkg::REDUCE_STEPS - 1);

   dbd_pkg::front_state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;

   logic [dbd_pkg::YEAR_W-1:0]  sy_ff, ey_ff, smod_ff, emod_ff;
   logic [dbd_pkg::MONTH_W-1:0] sm_ff, em_ff;
   logic [dbd_pkg::DAY_W-1:0]   sd_ff, ed_ff;

   logic accept;
   logic [dbd_pkg::YEAR_W-1:0] step_val;
   logic [dbd_pkg::MOD_W-1:0]  smod, emod;
   logic s_leap, e_leap;
   logic [8:0] s_term, e_term;

   assign accept   = req_valid && !req_stall;
   assign step_val = dbd_pkg::REDUCE_STEP[step_ff];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbd_pkg::F_IDLE:   if (req_valid) state_in = dbd_pkg::F_REDUCE;
         dbd_pkg::F_REDUCE: if (step_ff == LAST_STEP) state_in = dbd_pkg::F_PUSH;
         dbd_pkg::F_PUSH:   if (!job_full) state_in = dbd_pkg::F_IDLE;
         default:           state_in = dbd_pkg::F_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = 1'b1;
      job_push  = 1'b0;
      unique case (state_ff)
         dbd_pkg::F_IDLE:   req_stall = 1'b0;
         dbd_pkg::F_REDUCE: ;
         dbd_pkg::F_PUSH:   job_push = 1'b1;
         default:           ;
      endcase
   end

   // Step counter through the subtract ladder
   always_comb begin
      step_in = step_ff;
      if (accept) step_in = 3'd0;
      else if (state_ff == dbd_pkg::F_REDUCE && step_ff != LAST_STEP) step_in = step_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dbd_pkg::F_IDLE;
         step_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Capture the beat, then one compare-subtract per cycle on each year
   always_ff @(posedge clock) begin
      if (accept) begin
         sy_ff   <= req_start_year;
         sm_ff   <= req_start_month;
         sd_ff   <= req_start_day;
         ey_ff   <= req_end_year;
         em_ff   <= req_end_month;
         ed_ff   <= req_end_day;
         smod_ff <= req_start_year;
         emod_ff <= req_end_year;
      end else if (state_ff == dbd_pkg::F_REDUCE) begin
         if (smod_ff >= step_val) smod_ff <= smod_ff - step_val;
         if (emod_ff >= step_val) emod_ff <= emod_ff - step_val;
      end
   end

   // Month/day term: (end offset + end day) - (start offset + start day)
   assign smod   = smod_ff[dbd_pkg::MOD_W-1:0];
   assign emod   = emod_ff[dbd_pkg::MOD_W-1:0];
   assign s_leap = dbd_pkg::is_leap(sy_ff[1:0], smod);
   assign e_leap = dbd_pkg::is_leap(ey_ff[1:0], emod);
   assign s_term = dbd_pkg::days_before_month(sm_ff, s_leap) + {4'd0, sd_ff};
   assign e_term = dbd_pkg::days_before_month(em_ff, e_leap) + {4'd0, ed_ff};

   assign job.start_year = sy_ff;
   assign job.start_mod  = smod;
   assign job.end_year   = ey_ff;
   assign job.md_term    = $signed({1'b0, e_term}) - $signed({1'b0, s_term});

endmodule

[rtl/dbd_queue.sv]
// Short job queue between the front and back ends.
module dbd_queue #(
   parameter int DEPTH = dbd_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dbd_pkg::queue_ctl_type ctl,
   output dbd_pkg::queue_sts_type sts,
   input  dbd_pkg::job_type      wr_job,
   output dbd_pkg::job_type      rd_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dbd_pkg::job_type mem [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic do_push, do_pop;

   assign sts.full  = (count_ff == CNT_FULL);
   assign sts.empty = (count_ff == '0);
   assign do_push   = ctl.push && !sts.full;
   assign do_pop    = ctl.pop && !sts.empty;
   assign rd_job    = mem[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= wr_job;
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

endmodule

[rtl/dbd_back.sv]
// Back end: walks the whole years one per cycle, then adds the month/day term and saturates.
module dbd_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                job_empty,
   output logic                                job_pop,
   input  dbd_pkg::job_type                    job,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dbd_pkg::COUNT_W-1:0]  rsp_day_count
);

   localparam logic [dbd_pkg::MOD_W-1:0] MOD_LAST = 9'(dbd_pkg::YEAR_CYCLE - 1);
   localparam int SUM_W = dbd_pkg::ACC_W + 1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(dbd_pkg::COUNT_MAX);

   dbd_pkg::back_state_type state_ff, state_in;

   logic [dbd_pkg::YEAR_W-1:0]        cur_ff, ey_ff;
   logic [dbd_pkg::MOD_W-1:0]         mod_ff;
   logic [dbd_pkg::ACC_W-1:0]         acc_ff;
   logic signed [dbd_pkg::TERM_W-1:0] md_ff;
   logic                              rsp_valid_ff;
   logic signed [dbd_pkg::COUNT_W-1:0] rsp_day_count_ff;

   logic more_years, out_free, load_out;
   logic signed [SUM_W-1:0] total;
   logic [8:0] year_days;

   assign more_years = (cur_ff < ey_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign year_days  = dbd_pkg::is_leap(cur_ff[1:0], mod_ff) ? 9'(dbd_pkg::DAYS_LEAP)
                                                             : 9'(dbd_pkg::DAYS_COMMON);
   assign total      = $signed({1'b0, acc_ff}) + SUM_W'(md_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dbd_pkg::B_IDLE: if (!job_empty) state_in = dbd_pkg::B_LOOP;
         dbd_pkg::B_LOOP: if (!more_years) state_in = dbd_pkg::B_DONE;
         dbd_pkg::B_DONE: if (out_free) state_in = dbd_pkg::B_IDLE;
         default:         state_in = dbd_pkg::B_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      job_pop  = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         dbd_pkg::B_IDLE: job_pop = !job_empty;
         dbd_pkg::B_LOOP: ;
         dbd_pkg::B_DONE: load_out = out_free;
         default:         ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= dbd_pkg::B_IDLE;
      else       state_ff <= state_in;
   end

   // Year walk: one year a cycle, modulo-400 counter tracks the leap rule
   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job.start_year;
         mod_ff <= job.start_mod;
         ey_ff  <= job.end_year;
         md_ff  <= job.md_term;
         acc_ff <= '0;
      end else if (state_ff == dbd_pkg::B_LOOP && more_years) begin
         cur_ff <= cur_ff + 1'b1;
         mod_ff <= (mod_ff == MOD_LAST) ? '0 : mod_ff + 1'b1;
         acc_ff <= acc_ff + {15'd0, year_days};
      end
   end

   // Output register, saturated at the top of the field
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_day_count_ff <= (total > SUM_MAX) ? dbd_pkg::COUNT_W'(dbd_pkg::COUNT_MAX)
                                               : total[dbd_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_day_count = rsp_day_count_ff;

endmodule

[rtl/days_between_dates_unit.sv]
// Top level of the Gregorian date difference unit.
//
//   port group  dir  payload                                      flow control
//   req_*       in   start/end year, month, day                   req_valid / req_stall
//   rsp_*       out  rsp_day_count, 23-bit two's complement       rsp_valid / rsp_stall
//
// Per beat, the front captures it, runs six modulo-400 steps, then pushes; the push
// waits while the queue is full. The back walks the whole years, one per cycle, when
// end_year > start_year, then adds the month/day term and waits out a result stall.
// Reset: synchronous, active high; clears both state machines, the queue and rsp_valid.
// Stalls: a stalled result holds in the output register; the queue lets the front
// take new beats while the back is walking years or waiting on rsp_stall.
module days_between_dates_unit #(
   parameter int QUEUE_DEPTH = dbd_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dbd_pkg::YEAR_W-1:0]          req_start_year,
   input  logic [dbd_pkg::MONTH_W-1:0]         req_start_month,
   input  logic [dbd_pkg::DAY_W-1:0]           req_start_day,
   input  logic [dbd_pkg::YEAR_W-1:0]          req_end_year,
   input  logic [dbd_pkg::MONTH_W-1:0]         req_end_month,
   input  logic [dbd_pkg::DAY_W-1:0]           req_end_day,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dbd_pkg::COUNT_W-1:0]  rsp_day_count
);

   dbd_pkg::queue_ctl_type q_ctl;
   dbd_pkg::queue_sts_type q_sts;
   dbd_pkg::job_type       front_job, back_job;
   logic front_push, back_pop;

   assign q_ctl.push = front_push;
   assign q_ctl.pop  = back_pop;

   dbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_year  (req_start_year),
      .req_start_month (req_start_month),
      .req_start_day   (req_start_day),
      .req_end_year    (req_end_year),
      .req_end_month   (req_end_month),
      .req_end_day     (req_end_day),
      .job_push        (front_push),
      .job_full        (q_sts.full),
      .job             (front_job)
   );

   dbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl    (q_ctl),
      .sts    (q_sts),
      .wr_job (front_job),
      .rd_job (back_job)
   );

   dbd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_empty     (q_sts.empty),
      .job_pop       (back_pop),
      .job           (back_job),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_day_count (rsp_day_count)
   );

endmodule

[rtl/dbd_checker.sv]
// Port-level checker for the date difference unit, bound to the top level.
module dbd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [dbd_pkg::COUNT_W-1:0]  rsp_day_count
);

   // A stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_day_count))
      else $error("result beat changed under stall");

   // Reset leaves no result pending
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Front is busy reducing years after taking a beat
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("front took beats back to back");

   // Month/day term bounds the low end of any result
   a_rsp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_day_count >= -23'sd366))
      else $error("result below the month/day floor");

endmodule

bind days_between_dates_unit dbd_checker u_dbd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_day_count (rsp_day_count)
);

[dv/days_between_dates_unit_tb.sv]
// Self-checking testbench for the Gregorian date difference unit.
module days_between_dates_unit_tb;

   // Send or receive pause chance in percent, and length of the forced receiver hold-off
   localparam int IDLE_PCT       = 26;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOLD_AT_BEAT   = 60;
   localparam int CALM_FROM      = 150;
   localparam int CALM_TO        = 250;
   localparam int RANDOM_DATES   = 500;
   localparam int DRAIN_CYCLES   = 200;
   localparam int MAX_REPORTS    = 10;
   localparam int YEAR_TOP       = (1 << dbd_pkg::YEAR_W) - 1;

   // Days before each month in a common year, January to November
   localparam int MONTH_OFFSET [0:10] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304};

   typedef struct packed {
      logic [dbd_pkg::YEAR_W-1:0]  start_year;
      logic [dbd_pkg::MONTH_W-1:0] start_month;
      logic [dbd_pkg::DAY_W-1:0]   start_day;
      logic [dbd_pkg::YEAR_W-1:0]  end_year;
      logic [dbd_pkg::MONTH_W-1:0] end_month;
      logic [dbd_pkg::DAY_W-1:0]   end_day;
   } date_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [dbd_pkg::COUNT_W-1:0] rsp_day_count;
   date_pair_type beat = '0;

   date_pair_type               pending_dates[$];
   logic [dbd_pkg::COUNT_W-1:0] day_counts_due[$];
   int  sent_count = 0;
   int  checked_count = 0;
   int  error_count = 0;
   int  directed_count = 0;
   int  saturated_count = 0;
   int  negative_count = 0;
   int  widest_span = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   logic calm;
   logic hold_off;

   days_between_dates_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_year  (beat.start_year),
      .req_start_month (beat.start_month),
      .req_start_day   (beat.start_day),
      .req_end_year    (beat.end_year),
      .req_end_month   (beat.end_month),
      .req_end_day     (beat.end_day),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_day_count   (rsp_day_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both sides run without pauses for a stretch of beats
   assign calm     = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);
   assign hold_off = (hold_left != 0);

   // ---------------- calendar predictor ----------------
   function automatic bit leap_gregorian(input longint y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   // Days in all years 0 .. y-1
   function automatic longint days_to_year(input longint y);
      return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
   endfunction

   // Months outside 1 to 11 take the December offset
   function automatic longint days_to_month(input longint y,
                                            input logic [dbd_pkg::MONTH_W-1:0] m);
      longint off;
      if (m >= 1 && m <= 11) begin
         off = MONTH_OFFSET[int'(m) - 1];
         if (leap_gregorian(y) && m >= 3) off = off + 1;
      end else begin
         off = dbd_pkg::DEC_OFFSET + (leap_gregorian(y) ? 1 : 0);
      end
      return off;
   endfunction

   function automatic logic [dbd_pkg::COUNT_W-1:0] days_from_start_to_end(
         input date_pair_type p);
      longint total;
      total = 0;
      // whole years only count when the end year is later
      if (p.end_year > p.start_year)
         total = days_to_year(longint'(p.end_year)) - days_to_year(longint'(p.start_year));
      total = total + days_to_month(longint'(p.end_year), p.end_month) + longint'(p.end_day);
      total = total - days_to_month(longint'(p.start_year), p.start_month)
                    - longint'(p.start_day);
      if (total > dbd_pkg::COUNT_MAX) total = dbd_pkg::COUNT_MAX;
      return total[dbd_pkg::COUNT_W-1:0];
   endfunction

   // ---------------- stimulus helpers ----------------
   task automatic add_dates(input int sy, input int sm, input int sd,
                            input int ey, input int em, input int ed);
      date_pair_type p;
      p.start_year  = sy[dbd_pkg::YEAR_W-1:0];
      p.start_month = sm[dbd_pkg::MONTH_W-1:0];
      p.start_day   = sd[dbd_pkg::DAY_W-1:0];
      p.end_year    = ey[dbd_pkg::YEAR_W-1:0];
      p.end_month   = em[dbd_pkg::MONTH_W-1:0];
      p.end_day     = ed[dbd_pkg::DAY_W-1:0];
      if (ey - sy > widest_span) widest_span = ey - sy;
      pending_dates.push_back(p);
   endtask

   // Mostly plausible dates a century apart or less; a few odd or very wide requests
   task automatic add_random_dates();
      int pick, sy, ey, sm, sd, em, ed;
      pick = $urandom_range(0, 99);
      sm = $urandom_range(1, 12);
      em = $urandom_range(1, 12);
      sd = $urandom_range(1, 31);
      ed = $urandom_range(1, 31);
      if (pick < 70) begin
         sy = $urandom_range(1, 9999);
         ey = sy + $urandom_range(0, 100);
         if (ey > 9999) ey = 9999;
      end else if (pick < 80) begin
         sy = $urandom_range(0, YEAR_TOP);
         ey = sy + $urandom_range(0, 50);
         if (ey > YEAR_TOP) ey = YEAR_TOP;
      end else if (pick < 88) begin
         // end year before the start year
         sy = $urandom_range(1, YEAR_TOP);
         ey = $urandom_range(0, sy - 1);
      end else if (pick < 96) begin
         // any field value the ports allow
         sy = $urandom_range(0, YEAR_TOP);
         ey = sy + $urandom_range(0, 200);
         if (ey > YEAR_TOP) ey = YEAR_TOP;
         sm = $urandom_range(0, 15);
         em = $urandom_range(0, 15);
         sd = $urandom_range(0, 31);
         ed = $urandom_range(0, 31);
      end else if (pick < 99) begin
         sy = $urandom_range(1, 8000);
         ey = sy + $urandom_range(100, 2000);
      end else begin
         sy = $urandom_range(0, 200);
         ey = $urandom_range(9000, YEAR_TOP);
      end
      add_dates(sy, sm, sd, ey, em, ed);
   endtask

   task automatic note_failure(input string what, input logic [dbd_pkg::COUNT_W-1:0] want,
                               input logic [dbd_pkg::COUNT_W-1:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("[%0t] %s: expected %0d, got %0d", $time, what,
                  $signed(want), $signed(got));
   endtask

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      date_pair_type next_beat;
      logic [dbd_pkg::COUNT_W-1:0] due;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // accepted beat: predict its day count
         if (req_valid && !req_stall) begin
            due = days_from_start_to_end(beat);
            day_counts_due.push_back(due);
            sent_count <= sent_count + 1;
            if (due == dbd_pkg::COUNT_W'(dbd_pkg::COUNT_MAX))
               saturated_count <= saturated_count + 1;
            if (due[dbd_pkg::COUNT_W-1]) negative_count <= negative_count + 1;
         end
         // load the next beat unless one is being held
         if (!req_valid || !req_stall) begin
            if (pending_dates.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
               next_beat = pending_dates.pop_front();
               beat      <= next_beat;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver hold-off ----------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && sent_count == HOLD_AT_BEAT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      logic [dbd_pkg::COUNT_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_count <= checked_count + 1;
            if (day_counts_due.size() == 0) begin
               note_failure("result with none pending", '0, rsp_day_count);
            end else begin
               want = day_counts_due.pop_front();
               if (rsp_day_count !== want)
                  note_failure("day_count mismatch", want, rsp_day_count);
            end
         end
         rsp_stall <= hold_off || (!calm && $urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // ---------------- run control ----------------
   initial begin
      // identical dates, full range, saturation with year zero and stray months
      add_dates(2000, 1, 1, 2000, 1, 1);
      add_dates(1, 1, 1, 9999, 12, 31);
      add_dates(0, 0, 0, YEAR_TOP, 15, 31);
      // century and quad-century leap rule
      add_dates(1900, 1, 1, 1901, 1, 1);
      add_dates(2000, 1, 1, 2001, 1, 1);
      add_dates(2004, 2, 28, 2004, 3, 1);
      add_dates(2100, 2, 28, 2100, 3, 1);
      add_dates(1600, 12, 31, 1601, 1, 1);
      // end year before start year, most negative result
      add_dates(400, 12, 31, 0, 1, 0);
      add_dates(2020, 6, 15, 2019, 6, 15);
      // months outside 1 to 11 and unchecked days
      add_dates(2023, 13, 5, 2023, 14, 9);
      add_dates(2023, 0, 31, 2024, 15, 0);
      add_dates(12799, 11, 30, 12801, 2, 29);
      add_dates(YEAR_TOP, 1, 1, YEAR_TOP, 12, 31);
      add_dates(8191, 7, 16, 8192, 8, 15);
      add_dates(1, 1, 1, 1, 1, 31);
      add_dates(9999, 12, 31, 9999, 12, 31);
      directed_count = pending_dates.size();
      repeat (RANDOM_DATES) add_random_dates();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || req_valid) @(posedge clock);
      while (day_counts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (day_counts_due.size() != 0) begin
         error_count += day_counts_due.size();
         $display("%0d day counts never arrived", day_counts_due.size());
      end
      $display("Sent %0d date pairs (%0d directed), checked %0d day counts, %0d errors.",
               sent_count, directed_count, checked_count, error_count);
      $display("Widest year span %0d, %0d saturated and %0d negative counts.",
               widest_span, saturated_count, negative_count);
      if (error_count == 0) begin
         $display("** days_between_dates_unit: PASSED **");
      end else begin
         $display("** days_between_dates_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20_000_000;
      $display("Timeout with %0d day counts outstanding", day_counts_due.size());
      $display("** days_between_dates_unit: FAILED **");
      $finish;
   end

endmodule
